### hw/rtl/srclx_pkg.sv
// Shared types, token codes, character codes and classifier functions for the source lexer.
`timescale 1ns / 1ps

package srclx_pkg;

    localparam int KIND_W = 6;
    localparam int LEN_W  = 16;
    localparam int TAB_W  = 5;
    localparam int BYTE_W = 8;
    localparam int KW_COUNT = 9;
    localparam int KW_TEXT_W = 64;

    localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_NEWLINE  = 6'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 6'd1;
    localparam logic [KIND_W-1:0] KIND_STRING   = 6'd2;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 6'd3;
    localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 6'd4;
    localparam logic [KIND_W-1:0] KIND_EQ_EQ    = 6'd13;
    localparam logic [KIND_W-1:0] KIND_NOT_EQ   = 6'd14;
    localparam logic [KIND_W-1:0] KIND_LESS_EQ  = 6'd15;
    localparam logic [KIND_W-1:0] KIND_GREAT_EQ = 6'd16;
    localparam logic [KIND_W-1:0] KIND_AND_AND  = 6'd17;
    localparam logic [KIND_W-1:0] KIND_OR_OR    = 6'd18;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 6'd19;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 6'd20;
    localparam logic [KIND_W-1:0] KIND_STAR     = 6'd21;
    localparam logic [KIND_W-1:0] KIND_SLASH    = 6'd22;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 6'd23;
    localparam logic [KIND_W-1:0] KIND_LESS     = 6'd24;
    localparam logic [KIND_W-1:0] KIND_GREATER  = 6'd25;
    localparam logic [KIND_W-1:0] KIND_BANG     = 6'd26;
    localparam logic [KIND_W-1:0] KIND_SEMI     = 6'd27;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 6'd28;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 6'd29;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 6'd30;
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 6'd31;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 6'd32;
    localparam logic [KIND_W-1:0] KIND_EOF      = 6'd33;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 6'd34;
    // operator lookups return this when the byte is no operator
    localparam logic [KIND_W-1:0] KIND_NONE     = 6'd0;

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // keyword text, first character in the low byte, zero padded
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0074_656C,   // let
        64'h0000_0000_006E_7566,   // fun
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6C65,   // else
        64'h0000_0065_6C69_6877,   // while
        64'h0000_0000_6575_7274,   // true
        64'h0000_0065_736C_6166,   // false
        64'h0000_0074_6E69_7270,   // print
        64'h0000_6E72_7574_6572    // return
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd3, 4'd2, 4'd4, 4'd5, 4'd4, 4'd5, 4'd5, 4'd6
    };

    typedef struct packed {
        logic [7:0]        bad;
        logic [LEN_W-1:0]  length;
        logic [31:0]       start;
        logic [15:0]       column;
        logic [15:0]       line;
        logic [KIND_W-1:0] kind;
        logic              last;
    } token_t;

    function automatic logic digit_byte(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic letter_byte(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic opens_pair(input logic [7:0] c);
        return (c == CH_EQUAL) || (c == CH_BANG) || (c == CH_LESS) ||
               (c == CH_GREATER) || (c == CH_AMP) || (c == CH_PIPE) ||
               (c == CH_SLASH);
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            CH_PLUS:    k = KIND_PLUS;
            CH_MINUS:   k = KIND_MINUS;
            CH_STAR:    k = KIND_STAR;
            CH_SLASH:   k = KIND_SLASH;
            CH_EQUAL:   k = KIND_ASSIGN;
            CH_LESS:    k = KIND_LESS;
            CH_GREATER: k = KIND_GREATER;
            CH_BANG:    k = KIND_BANG;
            CH_SEMI:    k = KIND_SEMI;
            CH_COMMA:   k = KIND_COMMA;
            CH_LPAREN:  k = KIND_LPAREN;
            CH_RPAREN:  k = KIND_RPAREN;
            CH_LBRACE:  k = KIND_LBRACE;
            CH_RBRACE:  k = KIND_RBRACE;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [KIND_W-1:0] k;
        k = KIND_NONE;
        if (a == CH_EQUAL && b == CH_EQUAL)        k = KIND_EQ_EQ;
        else if (a == CH_BANG && b == CH_EQUAL)    k = KIND_NOT_EQ;
        else if (a == CH_LESS && b == CH_EQUAL)    k = KIND_LESS_EQ;
        else if (a == CH_GREATER && b == CH_EQUAL) k = KIND_GREAT_EQ;
        else if (a == CH_AMP && b == CH_AMP)       k = KIND_AND_AND;
        else if (a == CH_PIPE && b == CH_PIPE)     k = KIND_OR_OR;
        return k;
    endfunction

endpackage

### hw/rtl/srclx_core.sv
// Lexer state registers and the one-byte scan step producing up to two tokens.
`timescale 1ns / 1ps

module srclx_core #(
    parameter int KEYWORD_MAX_LEN = 6,
    parameter int COORD_WIDTH     = 16,
    parameter int POS_WIDTH       = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_valid,
    input  logic [7:0]                  step_byte,
    input  logic                        step_eos,
    input  logic [srclx_pkg::TAB_W-1:0] tab_advance,
    output srclx_pkg::token_t           res0,
    output srclx_pkg::token_t           res1,
    output logic [1:0]                  res_count
);
    import srclx_pkg::*;

    localparam int KW_BUF_W = 8 * KEYWORD_MAX_LEN;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_NUMBER  = 3'd1;
    localparam logic [2:0] MODE_IDENT   = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_COMMENT = 3'd4;
    localparam logic [2:0] MODE_OP      = 3'd5;

    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {COORD_WIDTH{1'b1}};
    localparam logic [COORD_WIDTH-1:0] COORD_ONE = COORD_WIDTH'(1);
    localparam logic [POS_WIDTH-1:0]   POS_MAX   = {POS_WIDTH{1'b1}};
    localparam logic [LEN_W-1:0]       LEN_MAX   = {LEN_W{1'b1}};

    logic [2:0]             mode_reg,  mode_next;
    logic [7:0]             pend_reg,  pend_next;
    logic                   dot_reg,   dot_next;
    logic [KW_BUF_W-1:0]    kw_reg,    kw_next;
    logic [COORD_WIDTH-1:0] line_reg,  line_next;
    logic [COORD_WIDTH-1:0] col_reg,   col_next;
    logic [POS_WIDTH-1:0]   pos_reg,   pos_next;
    logic [COORD_WIDTH-1:0] sline_reg, sline_next;
    logic [COORD_WIDTH-1:0] scol_reg,  scol_next;
    logic [POS_WIDTH-1:0]   spos_reg,  spos_next;
    logic [LEN_W-1:0]       len_reg,   len_next;

    logic [COORD_WIDTH-1:0] col_inc, col_tab, line_inc;
    logic [COORD_WIDTH:0]   col_tab_sum;
    logic [POS_WIDTH-1:0]   pos_inc;
    logic [LEN_W-1:0]       len_inc;
    logic [KIND_W-1:0]      kw_kind;

    function automatic logic [15:0] coord_out(input logic [COORD_WIDTH-1:0] v);
        logic [COORD_WIDTH+15:0] t;
        t = {16'd0, v};
        return t[15:0];
    endfunction

    function automatic logic [31:0] pos_out(input logic [POS_WIDTH-1:0] v);
        logic [POS_WIDTH+31:0] t;
        t = {32'd0, v};
        return t[31:0];
    endfunction

    function automatic token_t make_tok(
        input logic [KIND_W-1:0]      kind,
        input logic [COORD_WIDTH-1:0] line,
        input logic [COORD_WIDTH-1:0] col,
        input logic [POS_WIDTH-1:0]   pos,
        input logic [LEN_W-1:0]       len,
        input logic [7:0]             bad
    );
        token_t t;
        t.kind   = kind;
        t.line   = coord_out(line);
        t.column = coord_out(col);
        t.start  = pos_out(pos);
        t.length = len;
        t.bad    = bad;
        t.last   = 1'b0;
        return t;
    endfunction

    // saturating counter steps
    assign col_inc     = (col_reg == COORD_MAX) ? col_reg : col_reg + COORD_ONE;
    assign line_inc    = (line_reg == COORD_MAX) ? line_reg : line_reg + COORD_ONE;
    assign col_tab_sum = {1'b0, col_reg} + (COORD_WIDTH + 1)'(tab_advance);
    assign col_tab     = col_tab_sum[COORD_WIDTH] ? COORD_MAX : col_tab_sum[COORD_WIDTH-1:0];
    assign pos_inc     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_WIDTH'(1);
    assign len_inc     = (len_reg == LEN_MAX) ? len_reg : len_reg + LEN_W'(1);

    // parallel keyword compare; buffer bytes past the word are zero
    always_comb
    begin
        kw_kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if ((int'(KW_LEN[k]) <= KEYWORD_MAX_LEN) && (len_reg == LEN_W'(KW_LEN[k])) &&
                (KW_TEXT_W'(kw_reg) == KW_TEXT[k]))
            begin
                kw_kind = KIND_KEYWORD0 + KIND_W'(k);
            end
        end
    end

    always_comb
    begin
        token_t            held_tok, first_tok, second_tok;
        logic              first_vld, second_vld, flush, go_idle;
        logic [KIND_W-1:0] sk, pk;
        logic [7:0]        c;

        c          = step_byte;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        dot_next   = dot_reg;
        kw_next    = kw_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        spos_next  = spos_reg;
        len_next   = len_reg;
        first_vld  = 1'b0;
        second_vld = 1'b0;
        flush      = 1'b0;
        go_idle    = 1'b0;
        first_tok  = make_tok(KIND_NONE, line_reg, col_reg, pos_reg, '0, CH_NUL);
        second_tok = first_tok;

        // token held in the current mode, as emitted when it is cut off
        sk = single_kind(pend_reg);
        pk = pair_kind(pend_reg, c);
        unique case (mode_reg)
            MODE_NUMBER:
                held_tok = make_tok(KIND_NUMBER, sline_reg, scol_reg, spos_reg, len_reg, CH_NUL);
            MODE_IDENT:
                held_tok = make_tok(kw_kind, sline_reg, scol_reg, spos_reg, len_reg, CH_NUL);
            default:
            begin
                if (sk != KIND_NONE)
                    held_tok = make_tok(sk, sline_reg, scol_reg, spos_reg, '0, CH_NUL);
                else
                    held_tok = make_tok(KIND_ERROR, sline_reg, scol_reg, spos_reg, '0, pend_reg);
            end
        endcase

        if (step_eos)
        begin
            if (mode_reg == MODE_NUMBER || mode_reg == MODE_IDENT || mode_reg == MODE_OP)
            begin
                first_vld = 1'b1;
                first_tok = held_tok;
            end
            second_vld = 1'b1;
            second_tok = make_tok(KIND_EOF, line_reg, col_reg, pos_reg, '0, CH_NUL);
            mode_next  = MODE_IDLE;
            pend_next  = CH_NUL;
            dot_next   = 1'b0;
        end
        else
        begin
            pos_next = pos_inc;
            unique case (mode_reg)
                MODE_NUMBER:
                begin
                    if (digit_byte(c) || (c == CH_DOT && !dot_reg))
                    begin
                        if (c == CH_DOT)
                            dot_next = 1'b1;
                        len_next = len_inc;
                        col_next = col_inc;
                    end
                    else
                        flush = 1'b1;
                end
                MODE_IDENT:
                begin
                    if (letter_byte(c) || digit_byte(c))
                    begin
                        for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                        begin
                            if (len_reg == LEN_W'(i))
                                kw_next[8*i +: 8] = c;
                        end
                        len_next = len_inc;
                        col_next = col_inc;
                    end
                    else
                        flush = 1'b1;
                end
                MODE_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        first_vld = 1'b1;
                        first_tok = make_tok(KIND_STRING, sline_reg, scol_reg, spos_reg,
                                             len_reg, CH_NUL);
                        mode_next = MODE_IDLE;
                        col_next  = col_inc;
                    end
                    else
                    begin
                        len_next = len_inc;
                        if (c == CH_LF)
                        begin
                            line_next = line_inc;
                            col_next  = COORD_ONE;
                        end
                        else
                            col_next = col_inc;
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                        go_idle   = 1'b1;
                    end
                    else
                        col_next = col_inc;
                end
                MODE_OP:
                begin
                    if (pend_reg == CH_SLASH && c == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                        pend_next = CH_NUL;
                        col_next  = col_inc;
                    end
                    else if (pk != KIND_NONE)
                    begin
                        first_vld = 1'b1;
                        first_tok = make_tok(pk, sline_reg, scol_reg, spos_reg, '0, CH_NUL);
                        mode_next = MODE_IDLE;
                        pend_next = CH_NUL;
                        col_next  = col_inc;
                    end
                    else
                        flush = 1'b1;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    go_idle   = 1'b1;
                end
            endcase

            if (flush)
            begin
                first_vld = 1'b1;
                first_tok = held_tok;
                mode_next = MODE_IDLE;
                pend_next = CH_NUL;
                dot_next  = 1'b0;
                go_idle   = 1'b1;
            end

            // scan from idle; counters are untouched by the flush above
            if (go_idle)
            begin
                if (c == CH_SPACE || c == CH_CR)
                    col_next = col_inc;
                else if (c == CH_TAB)
                    col_next = col_tab;
                else if (c == CH_LF)
                begin
                    second_vld = 1'b1;
                    second_tok = make_tok(KIND_NEWLINE, line_reg, col_reg, pos_reg, '0, CH_NUL);
                    line_next  = line_inc;
                    col_next   = COORD_ONE;
                end
                else if (digit_byte(c) || letter_byte(c))
                begin
                    sline_next = line_reg;
                    scol_next  = col_reg;
                    spos_next  = pos_reg;
                    mode_next  = digit_byte(c) ? MODE_NUMBER : MODE_IDENT;
                    len_next   = LEN_W'(1);
                    dot_next   = 1'b0;
                    kw_next    = KW_BUF_W'(c);
                    col_next   = col_inc;
                end
                else if (c == CH_QUOTE)
                begin
                    sline_next = line_reg;
                    scol_next  = col_reg;
                    spos_next  = pos_reg;
                    mode_next  = MODE_STRING;
                    len_next   = '0;
                    col_next   = col_inc;
                end
                else if (opens_pair(c))
                begin
                    sline_next = line_reg;
                    scol_next  = col_reg;
                    spos_next  = pos_reg;
                    mode_next  = MODE_OP;
                    pend_next  = c;
                    col_next   = col_inc;
                end
                else
                begin
                    second_vld = 1'b1;
                    if (single_kind(c) != KIND_NONE)
                        second_tok = make_tok(single_kind(c), line_reg, col_reg, pos_reg,
                                              '0, CH_NUL);
                    else
                        second_tok = make_tok(KIND_ERROR, line_reg, col_reg, pos_reg, '0, c);
                    col_next = col_inc;
                end
            end
        end

        // compact into result slots, flag the final one
        second_tok.last = 1'b1;
        if (first_vld)
        begin
            first_tok.last = !second_vld;
            res0      = first_tok;
            res1      = second_tok;
            res_count = second_vld ? 2'd2 : 2'd1;
        end
        else
        begin
            res0      = second_tok;
            res1      = second_tok;
            res_count = second_vld ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= CH_NUL;
            dot_reg   <= 1'b0;
            kw_reg    <= '0;
            line_reg  <= COORD_ONE;
            col_reg   <= COORD_ONE;
            pos_reg   <= '0;
            sline_reg <= COORD_ONE;
            scol_reg  <= COORD_ONE;
            spos_reg  <= '0;
            len_reg   <= '0;
        end
        else if (step_valid)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            dot_reg   <= dot_next;
            kw_reg    <= kw_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            spos_reg  <= spos_next;
            len_reg   <= len_next;
        end
    end

endmodule

### hw/rtl/source_lexer.sv
// Top level of the streaming source lexer: input register, scan core and result queue.
`timescale 1ns / 1ps

// Streaming lexer. Source bytes enter one per transaction on the s_ side; a
// transaction with s_tlast set is the end marker, which flushes any held
// number, word or operator and emits an EOF token (its byte is ignored).
// Each byte yields zero, one or two tokens on the m_ side, the final token
// of a byte carrying m_tlast. A token that can still grow (number,
// identifier, keyword, operator) comes out when the byte after it arrives.
// Line, column and byte position are tracked with saturating counters;
// tab_advance (cfg port, reset 4) sets the columns a tab adds outside
// strings and comments, and is to be written only while the block is idle.
// Rate: one byte per clock while the result queue has room. The scan is a
// single combinational step from the input register into a four-entry result
// queue; a byte is taken from the input register when the queue holds two or
// fewer tokens. Each m_ transfer carries one token, so a byte with two tokens
// needs two transfers. With the queue empty, a byte passes the input register
// and the result queue before m_tvalid rises.

module source_lexer #(
    parameter int KEYWORD_MAX_LEN = 6,
    parameter int COORD_WIDTH     = 16,
    parameter int POS_WIDTH       = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // source byte stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] source_byte
    input  logic                        s_tlast,   // end_of_source
    // token stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [87:0]                 m_tdata,   // line, column, start, length, bad_byte
    output logic [5:0]                  m_tuser,   // token_kind
    output logic                        m_tlast,   // last_of_run
    // tab_advance register write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [srclx_pkg::TAB_W-1:0] cfg_data
);
    import srclx_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // input register
    logic             in_vld_reg, in_vld_next;
    logic [7:0]       in_byte_reg;
    logic             in_eos_reg;
    logic             s_accept;
    logic             step_fire;

    logic [TAB_W-1:0] tab_reg;

    token_t           res0, res1;
    logic [1:0]       res_count;

    // result queue
    token_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [QCNT_W-1:0]   push_cnt;
    logic                pop;
    logic [QPTR_W-1:0]   wr_ptr_plus1;
    token_t              head;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tab_reg <= TAB_RESET;
        else if (cfg_valid && cfg_ready)
            tab_reg <= cfg_data;
    end

    // room for the worst case of two tokens per byte
    assign step_fire   = in_vld_reg && (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign s_tready    = !in_vld_reg || step_fire;
    assign s_accept    = s_tvalid && s_tready;
    assign in_vld_next = s_accept ? 1'b1 : (step_fire ? 1'b0 : in_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    srclx_core #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
        .COORD_WIDTH     (COORD_WIDTH),
        .POS_WIDTH       (POS_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_valid  (step_fire),
        .step_byte   (in_byte_reg),
        .step_eos    (in_eos_reg),
        .tab_advance (tab_reg),
        .res0        (res0),
        .res1        (res1),
        .res_count   (res_count)
    );

    assign push_cnt     = step_fire ? QCNT_W'(res_count) : '0;
    assign pop          = m_tvalid && m_tready;
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + QPTR_W'(push_cnt);
    assign rd_ptr_next  = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
    assign cnt_next     = cnt_reg + push_cnt - (pop ? QCNT_W'(1) : QCNT_W'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && res_count != 2'd0)
            q_reg[wr_ptr_reg] <= res0;
        if (step_fire && res_count == 2'd2)
            q_reg[wr_ptr_plus1] <= res1;
    end

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {head.bad, head.length, head.start, head.column, head.line};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule

### verif/source_lexer_tb.sv
// Self-checking testbench for source_lexer: byte stream in, predicted tokens checked out.
`timescale 1ns / 1ps

module source_lexer_tb;

    import srclx_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;     // wait before each tab write, with margin
    localparam int DRAIN_CYCLES  = 10;
    localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction on any channel
    localparam int HOLD_AT       = 60;    // tokens seen before the long sink stall
    localparam int HOLD_CYCLES   = 200;
    localparam int KW_MAX        = 6;     // KEYWORD_MAX_LEN of the block
    localparam int MAX_REPORTS   = 50;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] source_byte
    logic                 s_tlast   = 1'b0; // end_of_source
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [87:0]          m_tdata;          // line, column, start, length, bad_byte
    logic [5:0]           m_tuser;          // token_kind
    logic                 m_tlast;          // last_of_run
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TAB_W-1:0]     cfg_data  = '0;

    source_lexer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer predictor: own copy of the scan state and the tab register
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {
        LX_IDLE, LX_NUMBER, LX_WORD, LX_STRING, LX_COMMENT, LX_OP
    } lex_mode_e;

    lex_mode_e          lx_mode   = LX_IDLE;
    logic [7:0]         held_char = '0;     // operator waiting for a possible second char
    logic               dot_seen  = 1'b0;
    logic [47:0]        word_bits = '0;     // first KW_MAX chars, first char low
    logic [15:0]        cur_line  = 16'd1;
    logic [15:0]        cur_col   = 16'd1;
    logic [31:0]        cur_pos   = '0;
    logic [15:0]        tok_line  = 16'd1;
    logic [15:0]        tok_col   = 16'd1;
    logic [31:0]        tok_pos   = '0;
    logic [15:0]        tok_len   = '0;
    logic [TAB_W-1:0]   tab_width = TAB_RESET;

    token_t step_out[$];     // tokens of the byte being predicted
    token_t due_tokens[$];   // predicted tokens not yet seen on m_

    string kw_names [9] = '{"let", "fun", "if", "else", "while",
                            "true", "false", "print", "return"};
    string op_texts [20] = '{"==", "!=", "<=", ">=", "&&", "||", "+", "-", "*", "/",
                             "=", "<", ">", "!", ";", ",", "(", ")", "{", "}"};

    function automatic logic [15:0] sat16(input logic [15:0] v, input logic [15:0] d);
        logic [16:0] s;
        s = {1'b0, v} + {1'b0, d};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [31:0] sat32_inc(input logic [31:0] v);
        logic [32:0] s;
        s = {1'b0, v} + 33'd1;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z) || c == CH_UNDER;
    endfunction

    function automatic logic [KIND_W-1:0] one_char_kind(input logic [7:0] c);
        case (c)
            CH_PLUS:    return KIND_PLUS;
            CH_MINUS:   return KIND_MINUS;
            CH_STAR:    return KIND_STAR;
            CH_SLASH:   return KIND_SLASH;
            CH_EQUAL:   return KIND_ASSIGN;
            CH_LESS:    return KIND_LESS;
            CH_GREATER: return KIND_GREATER;
            CH_BANG:    return KIND_BANG;
            CH_SEMI:    return KIND_SEMI;
            CH_COMMA:   return KIND_COMMA;
            CH_LPAREN:  return KIND_LPAREN;
            CH_RPAREN:  return KIND_RPAREN;
            CH_LBRACE:  return KIND_LBRACE;
            CH_RBRACE:  return KIND_RBRACE;
            default:    return KIND_NONE;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] two_char_kind(input logic [7:0] a,
                                                        input logic [7:0] b);
        if (a == CH_EQUAL && b == CH_EQUAL)   return KIND_EQ_EQ;
        if (a == CH_BANG && b == CH_EQUAL)    return KIND_NOT_EQ;
        if (a == CH_LESS && b == CH_EQUAL)    return KIND_LESS_EQ;
        if (a == CH_GREATER && b == CH_EQUAL) return KIND_GREAT_EQ;
        if (a == CH_AMP && b == CH_AMP)       return KIND_AND_AND;
        if (a == CH_PIPE && b == CH_PIPE)     return KIND_OR_OR;
        return KIND_NONE;
    endfunction

    // chars that may start a two-char operator or a comment
    function automatic logic pair_head(input logic [7:0] c);
        return c == CH_EQUAL || c == CH_BANG || c == CH_LESS || c == CH_GREATER ||
               c == CH_AMP || c == CH_PIPE || c == CH_SLASH;
    endfunction

    function automatic void add_token(input logic [KIND_W-1:0] kind,
                                      input logic [15:0] line, input logic [15:0] col,
                                      input logic [31:0] start, input logic [15:0] len,
                                      input logic [7:0] bad);
        token_t t;
        t.kind   = kind;
        t.line   = line;
        t.column = col;
        t.start  = start;
        t.length = len;
        t.bad    = bad;
        t.last   = 1'b0;
        step_out.push_back(t);
    endfunction

    // keyword lookup on the held word; longer words are plain identifiers
    function automatic logic [KIND_W-1:0] word_kind();
        logic [47:0] kw_bits;
        for (int k = 0; k < 9; k++) begin
            if (kw_names[k].len() <= KW_MAX && kw_names[k].len() == tok_len) begin
                kw_bits = '0;
                for (int j = 0; j < kw_names[k].len(); j++)
                    kw_bits[8*j +: 8] = kw_names[k][j];
                if (kw_bits == word_bits)
                    return KIND_KEYWORD0 + 6'(k);
            end
        end
        return KIND_IDENT;
    endfunction

    // emit a held number, word or operator; strings and comments stay
    function automatic void flush_held();
        case (lx_mode)
            LX_NUMBER: add_token(KIND_NUMBER, tok_line, tok_col, tok_pos, tok_len, 8'd0);
            LX_WORD:   add_token(word_kind(), tok_line, tok_col, tok_pos, tok_len, 8'd0);
            LX_OP:
                if (one_char_kind(held_char) != KIND_NONE)
                    add_token(one_char_kind(held_char), tok_line, tok_col, tok_pos,
                              16'd0, 8'd0);
                else
                    add_token(KIND_ERROR, tok_line, tok_col, tok_pos, 16'd0, held_char);
            default:   return;
        endcase
        lx_mode   = LX_IDLE;
        held_char = '0;
        dot_seen  = 1'b0;
    endfunction

    function automatic void mark_token();
        tok_line = cur_line;
        tok_col  = cur_col;
        tok_pos  = cur_pos;
    endfunction

    function automatic void start_word(input lex_mode_e mode, input logic [7:0] c);
        mark_token();
        lx_mode   = mode;
        tok_len   = 16'd1;
        dot_seen  = (c == CH_DOT);
        word_bits = {40'd0, c};
        cur_col   = sat16(cur_col, 16'd1);
    endfunction

    // byte seen with nothing held
    function automatic void idle_char(input logic [7:0] c);
        if (c == CH_SPACE || c == CH_CR) begin
            cur_col = sat16(cur_col, 16'd1);
        end else if (c == CH_TAB) begin
            cur_col = sat16(cur_col, 16'(tab_width));
        end else if (c == CH_LF) begin
            add_token(KIND_NEWLINE, cur_line, cur_col, cur_pos, 16'd0, 8'd0);
            cur_line = sat16(cur_line, 16'd1);
            cur_col  = 16'd1;
        end else if (digit_char(c)) begin
            start_word(LX_NUMBER, c);
        end else if (word_char(c)) begin
            start_word(LX_WORD, c);
        end else if (c == CH_QUOTE) begin
            mark_token();
            lx_mode = LX_STRING;
            tok_len = '0;
            cur_col = sat16(cur_col, 16'd1);
        end else if (pair_head(c)) begin
            mark_token();
            lx_mode   = LX_OP;
            held_char = c;
            cur_col   = sat16(cur_col, 16'd1);
        end else if (one_char_kind(c) != KIND_NONE) begin
            add_token(one_char_kind(c), cur_line, cur_col, cur_pos, 16'd0, 8'd0);
            cur_col = sat16(cur_col, 16'd1);
        end else begin
            // unexpected byte, NUL included
            add_token(KIND_ERROR, cur_line, cur_col, cur_pos, 16'd0, c);
            cur_col = sat16(cur_col, 16'd1);
        end
    endfunction

    // byte seen while a token is open; 1 when the byte is used up
    function automatic logic held_step(input logic [7:0] c);
        case (lx_mode)
            LX_NUMBER:
                if (digit_char(c) || (c == CH_DOT && !dot_seen)) begin
                    if (c == CH_DOT)
                        dot_seen = 1'b1;
                    tok_len = sat16(tok_len, 16'd1);
                    cur_col = sat16(cur_col, 16'd1);
                    return 1'b1;
                end
            LX_WORD:
                if (word_char(c) || digit_char(c)) begin
                    if (tok_len < KW_MAX)
                        word_bits[8*tok_len +: 8] = c;
                    tok_len = sat16(tok_len, 16'd1);
                    cur_col = sat16(cur_col, 16'd1);
                    return 1'b1;
                end
            LX_STRING:
            begin
                if (c == CH_QUOTE) begin
                    add_token(KIND_STRING, tok_line, tok_col, tok_pos, tok_len, 8'd0);
                    lx_mode = LX_IDLE;
                    cur_col = sat16(cur_col, 16'd1);
                end else begin
                    // a line feed is string content: no newline token
                    tok_len = sat16(tok_len, 16'd1);
                    if (c == CH_LF) begin
                        cur_line = sat16(cur_line, 16'd1);
                        cur_col  = 16'd1;
                    end else begin
                        cur_col = sat16(cur_col, 16'd1);
                    end
                end
                return 1'b1;
            end
            LX_COMMENT:
            begin
                if (c == CH_LF) begin
                    lx_mode = LX_IDLE;
                    return 1'b0;
                end
                cur_col = sat16(cur_col, 16'd1);
                return 1'b1;
            end
            LX_OP:
            begin
                if (held_char == CH_SLASH && c == CH_SLASH) begin
                    lx_mode   = LX_COMMENT;
                    held_char = '0;
                    cur_col   = sat16(cur_col, 16'd1);
                    return 1'b1;
                end
                if (two_char_kind(held_char, c) != KIND_NONE) begin
                    add_token(two_char_kind(held_char, c), tok_line, tok_col, tok_pos,
                              16'd0, 8'd0);
                    lx_mode   = LX_IDLE;
                    held_char = '0;
                    cur_col   = sat16(cur_col, 16'd1);
                    return 1'b1;
                end
            end
            default:
            begin
                lx_mode = LX_IDLE;
                return 1'b0;
            end
        endcase
        flush_held();
        return 1'b0;
    endfunction

    // predict the tokens of one accepted source transaction
    function automatic void lex_byte(input logic [7:0] c, input logic eos);
        token_t t;
        step_out.delete();
        if (eos) begin
            flush_held();   // an open string or comment is dropped
            add_token(KIND_EOF, cur_line, cur_col, cur_pos, 16'd0, 8'd0);
            lx_mode   = LX_IDLE;
            held_char = '0;
            dot_seen  = 1'b0;
        end else begin
            if (!held_step(c))
                idle_char(c);
            cur_pos = sat32_inc(cur_pos);
        end
        if (step_out.size() != 0) begin
            t = step_out[step_out.size() - 1];
            t.last = 1'b1;
            step_out[step_out.size() - 1] = t;
        end
        foreach (step_out[i])
            due_tokens.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // Source feed: byte transactions and tab register writes, in order
    // ------------------------------------------------------------------
    typedef enum logic {FEED_BYTE, FEED_TAB} feed_op_e;

    typedef struct {
        feed_op_e   op;
        logic [7:0] data;   // source byte, or tab width for FEED_TAB
        logic       eos;
        int         gap;    // idle cycles before the transaction is offered
    } feed_t;

    feed_t source_q[$];
    bit    quiet_feed = 1'b0;   // stretch with no sender idling

    task automatic queue_byte(input logic [7:0] c);
        feed_t f;
        f.op   = FEED_BYTE;
        f.data = c;
        f.eos  = 1'b0;
        f.gap  = quiet_feed ? 0 : $urandom_range(0, 5);
        source_q.push_back(f);
    endtask

    task automatic queue_end();
        feed_t f;
        f.op   = FEED_BYTE;
        f.data = 8'($urandom_range(0, 255));   // ignored by the block
        f.eos  = 1'b1;
        f.gap  = quiet_feed ? 0 : $urandom_range(0, 5);
        source_q.push_back(f);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    // the driver holds a tab write until all tokens are out and the block settles
    task automatic queue_tab(input int width);
        feed_t f;
        f.op   = FEED_TAB;
        f.data = 8'(width);
        f.eos  = 1'b0;
        f.gap  = 0;
        source_q.push_back(f);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CH_LOWER_A + 8'(r);
        if (r < 52)
            return CH_UPPER_A + 8'(r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // string or comment body: mostly printable, some line feeds and raw bytes
    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0:       c = CH_LF;
            1:       c = 8'($urandom_range(0, 255));
            default: c = 8'($urandom_range(32, 126));
        endcase
        return (c == CH_QUOTE) ? CH_UNDER : c;
    endfunction

    // mostly well-formed source with random content, some noise and broken input
    task automatic random_source(input int count);
        int first;
        int pick;
        first = source_q.size();
        while (source_q.size() - first < count) begin
            if ($urandom_range(0, 24) == 0)
                quiet_feed = !quiet_feed;
            pick = $urandom_range(0, 19);
            if (pick <= 2) begin
                repeat ($urandom_range(1, 5)) queue_byte(rand_digit());
                if ($urandom_range(0, 2) == 0) begin
                    queue_byte(CH_DOT);
                    repeat ($urandom_range(0, 3)) queue_byte(rand_digit());
                end
                if ($urandom_range(0, 7) == 0)
                    queue_byte(CH_DOT);   // a second dot ends the number, a first one extends it
            end else if (pick <= 5) begin
                queue_byte(rand_alpha());
                repeat ($urandom_range(0, 9))
                    queue_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha());
            end else if (pick <= 8) begin
                queue_text(kw_names[$urandom_range(0, 8)]);
                if ($urandom_range(0, 3) == 0)
                    queue_byte(rand_alpha());   // lengthened keyword is an identifier
            end else if (pick <= 12) begin
                queue_text(op_texts[$urandom_range(0, 19)]);
            end else if (pick <= 14) begin
                queue_byte(CH_QUOTE);
                repeat ($urandom_range(0, 8)) queue_byte(rand_text_char());
                queue_byte(CH_QUOTE);
            end else if (pick == 15) begin
                queue_text("//");
                repeat ($urandom_range(0, 6)) queue_byte(rand_text_char());
                queue_byte(CH_LF);
            end else if (pick <= 17) begin
                queue_byte(rand_blank());
            end else if (pick == 18) begin
                queue_byte(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 1) == 0) begin
                queue_end();
            end else begin
                queue_byte(($urandom_range(0, 1) == 0) ? CH_AMP : CH_PIPE);
            end
            if ($urandom_range(0, 1) == 0)
                queue_byte(rand_blank());
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the feed on s_ and cfg_, predicts on every transaction
    // ------------------------------------------------------------------
    feed_t tx_head;
    int    tx_hold  = 0;
    bit    tx_armed = 1'b0;
    logic  tx_valid_next;
    logic  tx_cfg_next;
    int    n_bytes      = 0;
    int    n_ends       = 0;
    int    n_tab_writes = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tlast   <= 1'b0;
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
            tx_hold   = 0;
            tx_armed  = 1'b0;
        end else begin
            tx_valid_next = s_tvalid;
            tx_cfg_next   = cfg_valid;
            if (s_tvalid && s_tready) begin
                lex_byte(s_tdata, s_tlast);
                if (s_tlast)
                    n_ends++;
                else
                    n_bytes++;
                void'(source_q.pop_front());
                tx_valid_next = 1'b0;
                tx_armed      = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                tab_width   = cfg_data;
                n_tab_writes++;
                void'(source_q.pop_front());
                tx_cfg_next = 1'b0;
                tx_armed    = 1'b0;
            end
            if (!tx_valid_next && !tx_cfg_next && source_q.size() != 0) begin
                tx_head = source_q[0];
                if (!tx_armed) begin
                    tx_hold  = (tx_head.op == FEED_TAB) ? SETTLE_CYCLES : tx_head.gap;
                    tx_armed = 1'b1;
                end
                if (tx_head.op == FEED_TAB && due_tokens.size() != 0) begin
                    // the sender pauses here until every token has come out
                    tx_hold = SETTLE_CYCLES;
                end else if (tx_hold != 0) begin
                    tx_hold--;
                end else if (tx_head.op == FEED_TAB) begin
                    cfg_data    <= tx_head.data[TAB_W-1:0];
                    tx_cfg_next = 1'b1;
                end else begin
                    s_tdata       <= tx_head.data;
                    s_tlast       <= tx_head.eos;
                    tx_valid_next = 1'b1;
                end
            end
            s_tvalid  <= tx_valid_next;
            cfg_valid <= tx_cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random sink stalls, one long hold-off, field checks
    // ------------------------------------------------------------------
    int   n_tokens   = 0;
    int   fail_count = 0;
    int   rx_wait    = 0;
    int   rx_hold    = 0;
    bit   hold_done  = 1'b0;
    logic rx_ready_next;
    bit   seen_kinds [0:34];

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (fail_count < MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_token();
        token_t want;
        if (m_tuser <= KIND_ERROR)
            seen_kinds[m_tuser] = 1'b1;
        n_tokens++;
        if (due_tokens.size() == 0) begin
            if (fail_count < MAX_REPORTS)
                $error("token kind %0d arrived with nothing expected", m_tuser);
            fail_count++;
        end else begin
            want = due_tokens.pop_front();
            check_field("token_kind",   32'(want.kind),   32'(m_tuser));
            check_field("token_line",   32'(want.line),   32'(m_tdata[15:0]));
            check_field("token_column", 32'(want.column), 32'(m_tdata[31:16]));
            check_field("token_start",  want.start,       m_tdata[63:32]);
            check_field("token_length", 32'(want.length), 32'(m_tdata[79:64]));
            check_field("bad_byte",     32'(want.bad),    32'(m_tdata[87:80]));
            check_field("last_of_run",  32'(want.last),   32'(m_tlast));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
            rx_hold  = 0;
        end else begin
            rx_ready_next = m_tready;
            if (m_tvalid && m_tready) begin
                check_token();
                rx_ready_next = 1'b0;
                // every third block of 40 tokens runs without sink stalls
                rx_wait = ((n_tokens / 40) % 3 == 2) ? 0 : $urandom_range(0, 5);
            end
            // long hold-off while the source keeps offering: queue fills, s_tready drops
            if (!hold_done && n_tokens >= HOLD_AT && s_tvalid) begin
                hold_done = 1'b1;
                rx_hold   = HOLD_CYCLES;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                rx_ready_next = 1'b0;
            end else if (!rx_ready_next) begin
                if (rx_wait != 0)
                    rx_wait--;
                else
                    rx_ready_next = 1'b1;
            end
            m_tready <= rx_ready_next;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when no channel moves for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d tokens outstanding",
                         IDLE_LIMIT, due_tokens.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int kinds_hit;

        // directed: reset tab width, number with second dot, lone & and |,
        // string over a line feed, comment, NUL and 0xFF bytes, open string at end
        quiet_feed = 1'b0;
        queue_text("1.5.\t&a|\"q\nz\"//c\n");
        queue_byte(CH_NUL);
        queue_byte(8'hFF);
        queue_text("\"ab");
        queue_end();

        // random phases, each under its own tab width
        queue_tab(1);
        random_source(90);
        queue_tab(16);
        random_source(90);
        queue_tab(11);
        random_source(90);
        queue_tab(4);
        random_source(90);

        // short closing phase, starting without sender gaps
        queue_tab(16);
        quiet_feed = 1'b1;
        random_source(20);
        queue_end();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (source_q.size() != 0 || due_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        kinds_hit = 0;
        foreach (seen_kinds[k])
            if (seen_kinds[k])
                kinds_hit++;
        $display("Run: %0d source bytes, %0d end markers, %0d tokens checked, %0d of 35 kinds",
                 n_bytes, n_ends, n_tokens, kinds_hit);
        $display("Tab widths 4/1/16/11/4/16 over %0d writes; one long sink stall, idle drains",
                 n_tab_writes);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
hw/rtl/srclx_pkg.sv
hw/rtl/srclx_core.sv
hw/rtl/source_lexer.sv
verif/source_lexer_tb.sv
